>>> hdl/sle_pkg.sv
// Shared types, codes and key tables for the scancode line editor.
// No dependencies; imported by every module of the block.
package sle_pkg;

    localparam logic [7:0] SC_PREFIX    = 8'hE0;
    localparam logic [7:0] SC_RELEASE   = 8'h80;
    localparam logic [6:0] SC_KEY_MASK  = 7'h7F;
    localparam logic [6:0] SC_LSHIFT    = 7'h2A;
    localparam logic [6:0] SC_RSHIFT    = 7'h36;
    localparam logic [6:0] SC_CAPS      = 7'h3A;

    localparam logic [6:0] CH_NONE      = 7'h00;
    localparam logic [6:0] CH_BS        = 7'h08;
    localparam logic [6:0] CH_NL        = 7'h0A;
    localparam logic [6:0] CH_LOWER_A   = 7'h61;
    localparam logic [6:0] CH_LOWER_Z   = 7'h7A;
    localparam logic [6:0] CH_CASE_BIT  = 7'h20;

    localparam logic [5:0] CAP_MAX      = 6'd63;

    typedef enum logic [1:0] {
        KIND_ECHO     = 2'd0,
        KIND_LINE     = 2'd1,
        KIND_NO_LINE  = 2'd2,
        KIND_EMPTY    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CMD_CHAR      = 2'd0,
        CMD_NEWLINE   = 2'd1,
        CMD_BACKSPACE = 2'd2,
        CMD_READ      = 2'd3
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [6:0] ch;
        logic [5:0] cap;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE  = 2'd0,
        B_FETCH = 2'd1,
        B_EMIT  = 2'd2
    } back_state_t;

    function automatic logic [6:0] key_map(input logic [6:0] code);
        logic [6:0] c;
        unique case (code)
            7'h01: c = 7'h1B;
            7'h02: c = 7'h31;
            7'h03: c = 7'h32;
            7'h04: c = 7'h33;
            7'h05: c = 7'h34;
            7'h06: c = 7'h35;
            7'h07: c = 7'h36;
            7'h08: c = 7'h37;
            7'h09: c = 7'h38;
            7'h0A: c = 7'h39;
            7'h0B: c = 7'h30;
            7'h0C: c = 7'h2D;
            7'h0D: c = 7'h3D;
            7'h0E: c = 7'h08;
            7'h0F: c = 7'h09;
            7'h10: c = 7'h71;
            7'h11: c = 7'h77;
            7'h12: c = 7'h65;
            7'h13: c = 7'h72;
            7'h14: c = 7'h74;
            7'h15: c = 7'h79;
            7'h16: c = 7'h75;
            7'h17: c = 7'h69;
            7'h18: c = 7'h6F;
            7'h19: c = 7'h70;
            7'h1A: c = 7'h5B;
            7'h1B: c = 7'h5D;
            7'h1C: c = 7'h0A;
            7'h1E: c = 7'h61;
            7'h1F: c = 7'h73;
            7'h20: c = 7'h64;
            7'h21: c = 7'h66;
            7'h22: c = 7'h67;
            7'h23: c = 7'h68;
            7'h24: c = 7'h6A;
            7'h25: c = 7'h6B;
            7'h26: c = 7'h6C;
            7'h27: c = 7'h3B;
            7'h28: c = 7'h27;
            7'h29: c = 7'h60;
            7'h2B: c = 7'h5C;
            7'h2C: c = 7'h7A;
            7'h2D: c = 7'h78;
            7'h2E: c = 7'h63;
            7'h2F: c = 7'h76;
            7'h30: c = 7'h62;
            7'h31: c = 7'h6E;
            7'h32: c = 7'h6D;
            7'h33: c = 7'h2C;
            7'h34: c = 7'h2E;
            7'h35: c = 7'h2F;
            7'h37: c = 7'h2A;
            7'h39: c = 7'h20;
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] shift_map(input logic [6:0] ch);
        logic [6:0] c;
        unique case (ch)
            7'h31: c = 7'h21;
            7'h32: c = 7'h40;
            7'h33: c = 7'h23;
            7'h34: c = 7'h24;
            7'h35: c = 7'h25;
            7'h36: c = 7'h5E;
            7'h37: c = 7'h26;
            7'h38: c = 7'h2A;
            7'h39: c = 7'h28;
            7'h30: c = 7'h29;
            7'h2D: c = 7'h5F;
            7'h3D: c = 7'h2B;
            7'h5C: c = 7'h7C;
            7'h3B: c = 7'h3A;
            7'h27: c = 7'h22;
            7'h2C: c = 7'h3C;
            7'h2E: c = 7'h3E;
            7'h2F: c = 7'h3F;
            7'h60: c = 7'h7E;
            7'h5B: c = 7'h7B;
            7'h5D: c = 7'h7D;
            default: c = ch;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/scancode_line_editor.sv
// Scancode line editor: set-1 scancodes build an ASCII line; read requests stream it out.
// Path: an echo passes through the command queue and the result register; a read's first
// byte also passes the B_FETCH state and the registered line-store read port.
// Throughput: one scancode per cycle through the 2-entry queue while the queue is not full;
// a read holds the back end off new commands while it fetches then emits each stored byte.
// Reset: rst_n asynchronous, clears flags, line length, ready flag and queue; store undefined.
module scancode_line_editor
#(
    parameter int LINE_BYTES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] scancode, [14:8] max_len, [15] zero
    input  logic [0:0]  s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] char_out, [12:7] line_count, [15:13] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);
    import sle_pkg::*;

    logic       push;
    cmd_t       push_cmd;
    logic       q_full;
    logic       pop;
    logic       q_valid;
    cmd_t       q_cmd;
    logic [6:0] char_out;
    logic [5:0] line_count;

    sle_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser[0]),
        .in_code    (s_tdata[7:0]),
        .in_max_len (s_tdata[14:8]),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    sle_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    sle_back #(.LINE_BYTES(LINE_BYTES)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_char  (char_out),
        .out_last  (m_tlast),
        .out_count (line_count)
    );

    assign m_tdata = {3'b000, line_count, char_out};

endmodule

>>> hdl/sle_front.sv
// Front end: accepts items, tracks shift, caps lock and prefix flags, maps keys
// and issues line commands. Depends on sle_pkg.
module sle_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          in_mode,
    input  logic [7:0]    in_code,
    input  logic [6:0]    in_max_len,
    input  logic          q_full,
    output logic          push,
    output sle_pkg::cmd_t push_cmd
);
    import sle_pkg::*;

    logic       shift_reg, shift_next;
    logic       caps_reg, caps_next;
    logic       prefix_reg, prefix_next;
    logic       accept;
    logic [6:0] key;
    logic [6:0] mapped;
    logic [6:0] ch;
    logic [6:0] cap7;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign key      = in_code[6:0] & SC_KEY_MASK;
    assign mapped   = key_map(key);
    assign cap7     = (in_max_len == 7'd0) ? 7'd0 : in_max_len - 7'd1;

    always_comb
    begin
        shift_next    = shift_reg;
        caps_next     = caps_reg;
        prefix_next   = prefix_reg;
        push          = 1'b0;
        push_cmd.op   = CMD_READ;
        push_cmd.ch   = CH_NONE;
        push_cmd.cap  = (cap7 > 7'(CAP_MAX)) ? CAP_MAX : cap7[5:0];
        ch            = mapped;
        if ((mapped >= CH_LOWER_A) && (mapped <= CH_LOWER_Z))
        begin
            if (caps_reg != shift_reg)
                ch = mapped & ~CH_CASE_BIT;
        end
        else if (shift_reg)
        begin
            ch = shift_map(mapped);
        end
        push_cmd.ch = ch;
        if (accept)
        begin
            if (in_mode)
            begin
                push = 1'b1;
            end
            else
            begin
                priority if (in_code == SC_PREFIX)
                begin
                    prefix_next = 1'b1;
                end
                else if ((in_code & SC_RELEASE) != 8'd0)
                begin
                    if ((key == SC_LSHIFT) || (key == SC_RSHIFT))
                        shift_next = 1'b0;
                    prefix_next = 1'b0;
                end
                else if ((key == SC_LSHIFT) || (key == SC_RSHIFT))
                begin
                    shift_next = 1'b1;
                end
                else if (key == SC_CAPS)
                begin
                    caps_next = !caps_reg;
                end
                else if (prefix_reg)
                begin
                    prefix_next = 1'b0;
                end
                else if (mapped != CH_NONE)
                begin
                    push = 1'b1;
                    priority if (ch == CH_BS)
                        push_cmd.op = CMD_BACKSPACE;
                    else if (ch == CH_NL)
                        push_cmd.op = CMD_NEWLINE;
                    else
                        push_cmd.op = CMD_CHAR;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= 1'b0;
            caps_reg   <= 1'b0;
            prefix_reg <= 1'b0;
        end
        else
        begin
            shift_reg  <= shift_next;
            caps_reg   <= caps_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

>>> hdl/sle_queue.sv
// Two-entry command queue between front and back end.
// Depends on sle_pkg.
module sle_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sle_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output sle_pkg::cmd_t q_cmd
);
    import sle_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

>>> hdl/sle_back.sv
// Back end: owns the line store, length and ready flag, executes commands
// and drives the result register. Depends on sle_pkg.
module sle_back
#(
    parameter int LINE_BYTES = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  sle_pkg::cmd_t q_cmd,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    out_kind,
    output logic [6:0]    out_char,
    output logic          out_last,
    output logic [5:0]    out_count
);
    import sle_pkg::*;

    localparam int         LW      = $clog2(LINE_BYTES);
    localparam int         DEPTH   = LINE_BYTES - 1;
    localparam logic [LW-1:0] FULL_LEN = LW'(LINE_BYTES - 1);

    logic [6:0]    mem [DEPTH];

    back_state_t   state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic          ready_reg, ready_next;
    logic [LW-1:0] copy_reg, copy_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [6:0]    rd_data_reg;
    logic          valid_reg, valid_next;
    logic [1:0]    kind_reg, kind_next;
    logic [6:0]    char_reg, char_next;
    logic          last_reg, last_next;
    logic [5:0]    count_reg, count_next;
    logic          out_free;
    logic          load;
    logic          mem_we;
    logic [5:0]    len6;
    logic [5:0]    copy6;
    logic          is_last;

    assign out_free  = !valid_reg || out_ready;
    assign len6      = 6'(len_reg);
    assign copy6     = (len6 < q_cmd.cap) ? len6 : q_cmd.cap;
    assign is_last   = (LW'(idx_reg + 1'b1) == copy_reg);
    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;
    assign out_count = count_reg;

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        ready_next = ready_reg;
        copy_next  = copy_reg;
        idx_next   = idx_reg;
        kind_next  = kind_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        count_next = count_reg;
        load       = 1'b0;
        mem_we     = 1'b0;
        pop        = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    pop        = 1'b1;
                    kind_next  = KIND_ECHO;
                    char_next  = q_cmd.ch;
                    last_next  = 1'b1;
                    count_next = 6'd0;
                    unique case (q_cmd.op)
                        CMD_CHAR:
                        begin
                            if (len_reg != FULL_LEN)
                            begin
                                mem_we   = 1'b1;
                                len_next = len_reg + 1'b1;
                                load     = 1'b1;
                            end
                        end
                        CMD_NEWLINE:
                        begin
                            if (len_reg != FULL_LEN)
                            begin
                                mem_we   = 1'b1;
                                len_next = len_reg + 1'b1;
                            end
                            ready_next = 1'b1;
                            load       = 1'b1;
                        end
                        CMD_BACKSPACE:
                        begin
                            if (len_reg != '0)
                            begin
                                len_next  = len_reg - 1'b1;
                                char_next = CH_BS;
                                load      = 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            char_next = CH_NONE;
                            if (!ready_reg)
                            begin
                                kind_next = KIND_NO_LINE;
                                load      = 1'b1;
                            end
                            else
                            begin
                                len_next   = '0;
                                ready_next = 1'b0;
                                if (copy6 == 6'd0)
                                begin
                                    kind_next = KIND_EMPTY;
                                    load      = 1'b1;
                                end
                                else
                                begin
                                    copy_next  = LW'(copy6);
                                    idx_next   = '0;
                                    state_next = B_FETCH;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_FETCH:
            begin
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    kind_next  = KIND_LINE;
                    char_next  = rd_data_reg;
                    last_next  = is_last;
                    count_next = 6'(copy_reg);
                    if (is_last)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = B_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            len_reg   <= '0;
            ready_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ready_reg <= ready_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        copy_reg  <= copy_next;
        idx_reg   <= idx_next;
        kind_reg  <= kind_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[len_reg] <= q_cmd.ch;
        if (state_reg == B_FETCH)
            rd_data_reg <= mem[idx_reg];
    end

endmodule

>>> bench/testbench.sv
// Self-checking bench for scancode_line_editor: key handling, line edits and line reads.
// Holds its own predictor of the editor; depends on sle_pkg and the editor RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sle_pkg::*;

    localparam int          LINE_BYTES    = 64;
    localparam int          STORE_DEPTH   = LINE_BYTES - 1;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned RANDOM_GOAL   = 330;

    localparam logic [7:0]  KEY_NONE      = 8'h00;
    localparam logic [7:0]  KEY_1         = 8'h02;
    localparam logic [7:0]  KEY_BACKSPACE = 8'h0E;
    localparam logic [7:0]  KEY_Q         = 8'h10;
    localparam logic [7:0]  KEY_ENTER     = 8'h1C;
    localparam logic [7:0]  KEY_A         = 8'h1E;
    localparam logic [7:0]  KEY_F1        = 8'h3B;
    localparam logic [7:0]  KEY_UP        = 8'h48;
    localparam logic [7:0]  KEY_UP_BREAK  = SC_RELEASE | KEY_UP;
    localparam logic [7:0]  LSHIFT_MAKE   = {1'b0, SC_LSHIFT};
    localparam logic [7:0]  RSHIFT_MAKE   = {1'b0, SC_RSHIFT};
    localparam logic [7:0]  LSHIFT_BREAK  = SC_RELEASE | {1'b0, SC_LSHIFT};
    localparam logic [7:0]  RSHIFT_BREAK  = SC_RELEASE | {1'b0, SC_RSHIFT};
    localparam logic [7:0]  CAPS_MAKE     = {1'b0, SC_CAPS};

    localparam logic [0:57][6:0] KEY_CHARS = {
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20
    };
    localparam logic [0:20][6:0] PLAIN_SYMBOLS = {
        7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30, 7'h2D,
        7'h3D, 7'h5C, 7'h3B, 7'h27, 7'h2C, 7'h2E, 7'h2F, 7'h60, 7'h5B, 7'h5D
    };
    localparam logic [0:20][6:0] SHIFTED_SYMBOLS = {
        7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F,
        7'h2B, 7'h7C, 7'h3A, 7'h22, 7'h3C, 7'h3E, 7'h3F, 7'h7E, 7'h7B, 7'h7D
    };

    typedef struct packed {
        kind_t      kind;
        logic [6:0] ch;
        logic       last;
        logic [5:0] count;
    } editor_out_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [7:0] scancode, [14:8] max_len, [15] zero
    logic [0:0]  s_tuser  = '0;   // [0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [6:0] char_out, [12:7] line_count, [15:13] zero
    logic [1:0]  m_tuser;         // [1:0] kind
    logic        m_tlast;

    editor_out_t results_due[$];
    logic [6:0]  line_buf[0:STORE_DEPTH-1];
    int unsigned line_len;
    bit          line_done;
    bit          shift_down;
    bit          caps_lock;
    bit          e0_pending;

    bit          send_idle_on  = 1'b1;
    bit          recv_stall_on = 1'b1;
    int unsigned items_sent;
    int unsigned reads_sent;
    int unsigned results_checked;
    int unsigned mismatches;
    int unsigned cycle_count;
    editor_out_t want;

    scancode_line_editor #(
        .LINE_BYTES (LINE_BYTES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void expect_out(kind_t k, logic [6:0] c, logic l, logic [5:0] n);
        editor_out_t r;
        r.kind  = k;
        r.ch    = c;
        r.last  = l;
        r.count = n;
        results_due.push_back(r);
    endfunction

    function automatic logic [6:0] apply_shift(logic [6:0] c);
        logic [6:0] r;
        r = c;
        for (int i = 0; i < 21; i++)
        begin
            if (PLAIN_SYMBOLS[i] == c)
                r = SHIFTED_SYMBOLS[i];
        end
        return r;
    endfunction

    function automatic void edit_line(logic [7:0] code);
        logic [6:0] c;
        c = CH_NONE;
        if (code == SC_PREFIX)
            e0_pending = 1'b1;
        else if ((code & SC_RELEASE) != 8'h00)
        begin
            if (code[6:0] == SC_LSHIFT || code[6:0] == SC_RSHIFT)
                shift_down = 1'b0;
            e0_pending = 1'b0;
        end
        else if (code[6:0] == SC_LSHIFT || code[6:0] == SC_RSHIFT)
            shift_down = 1'b1;
        else if (code[6:0] == SC_CAPS)
            caps_lock = !caps_lock;
        else if (e0_pending)
            e0_pending = 1'b0;
        else
        begin
            if (code <= 8'h39)
                c = KEY_CHARS[code[5:0]];
            if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            begin
                if (caps_lock != shift_down)
                    c = c ^ CH_CASE_BIT;
            end
            else if (shift_down)
                c = apply_shift(c);
            if (c == CH_BS)
            begin
                if (line_len > 0)
                begin
                    line_len--;
                    expect_out(KIND_ECHO, CH_BS, 1'b1, 6'd0);
                end
            end
            else if (c == CH_NL)
            begin
                if (line_len < STORE_DEPTH)
                    line_buf[line_len++] = CH_NL;
                line_done = 1'b1;
                expect_out(KIND_ECHO, CH_NL, 1'b1, 6'd0);
            end
            else if (c != CH_NONE && line_len < STORE_DEPTH)
            begin
                line_buf[line_len++] = c;
                expect_out(KIND_ECHO, c, 1'b1, 6'd0);
            end
        end
    endfunction

    function automatic void read_line(logic [6:0] size);
        int unsigned room;
        int unsigned n;
        if (!line_done)
        begin
            expect_out(KIND_NO_LINE, CH_NONE, 1'b1, 6'd0);
            return;
        end
        room = (size >= 7'd1) ? size - 1 : 0;
        n    = (line_len > room) ? room : line_len;
        if (n > STORE_DEPTH)
            n = STORE_DEPTH;
        line_len  = 0;
        line_done = 1'b0;
        if (n == 0)
            expect_out(KIND_EMPTY, CH_NONE, 1'b1, 6'd0);
        for (int unsigned i = 0; i < n; i++)
            expect_out(KIND_LINE, line_buf[i], i + 1 == n, 6'(n));
    endfunction

    task automatic send_request(input logic mode, input logic [7:0] code,
                                input logic [6:0] size);
        int unsigned gap;
        gap = 0;
        if (send_idle_on)
        begin
            while ($urandom_range(99) < 29 && gap < 12)
                gap++;
        end
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, size, code};
        do
            @(posedge clk);
        while (!s_tready);
        if (mode)
        begin
            read_line(size);
            reads_sent++;
        end
        else
            edit_line(code);
        items_sent++;
    endtask

    task automatic send_key(input logic [7:0] code);
        send_request(1'b0, code, 7'($urandom_range(127)));
    endtask

    task automatic send_read(input logic [6:0] size);
        send_request(1'b1, 8'($urandom_range(255)), size);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] random_char_code();
        logic [7:0] code;
        logic [6:0] c;
        do
        begin
            code = 8'($urandom_range(1, 57));
            c    = KEY_CHARS[code[5:0]];
        end
        while (c == CH_NONE || c == CH_BS || c == CH_NL);
        return code;
    endfunction

    task automatic test_keymap();
        send_read(7'd64);
        send_key(KEY_BACKSPACE);
        send_key(KEY_A);
        send_key(LSHIFT_MAKE);
        send_key(KEY_A);
        send_key(KEY_1);
        send_key(LSHIFT_BREAK);
        send_key(CAPS_MAKE);
        send_key(KEY_Q);
        send_key(RSHIFT_MAKE);
        send_key(KEY_Q);
        send_key(RSHIFT_BREAK);
        send_key(CAPS_MAKE);
        send_key(SC_PREFIX);
        send_key(KEY_UP);
        send_key(SC_PREFIX);
        send_key(LSHIFT_MAKE);
        send_key(KEY_A);
        send_key(LSHIFT_BREAK);
        send_key(SC_PREFIX);
        send_key(KEY_UP_BREAK);
        send_key(KEY_A);
        send_key(KEY_NONE);
        send_key(KEY_F1);
        send_key(KEY_BACKSPACE);
    endtask

    task automatic test_read_cases();
        send_key(KEY_ENTER);
        send_key(KEY_BACKSPACE);
        send_read(7'd3);
        send_key(KEY_A);
        send_key(KEY_ENTER);
        send_read(7'd0);
        send_key(KEY_ENTER);
        send_key(KEY_BACKSPACE);
        send_read(7'd64);
        send_key(KEY_A);
        send_key(KEY_ENTER);
        send_read(7'd1);
        send_read(7'd64);
    endtask

    task automatic test_full_line();
        drain_results();
        send_key(KEY_ENTER);
        send_read(7'd64);
        repeat (66) send_key(random_char_code());
        send_key(KEY_ENTER);
        send_read(7'd64);
    endtask

    task automatic test_random_lines(input int unsigned item_goal);
        int unsigned span;
        int unsigned pick;
        while (items_sent < item_goal)
        begin
            span = ($urandom_range(7) == 0) ? $urandom_range(30, 62) : $urandom_range(0, 12);
            repeat (span)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                    send_key(random_char_code());
                else if (pick < 63)
                    send_key(KEY_BACKSPACE);
                else if (pick < 69)
                    send_key($urandom_range(1) ? LSHIFT_MAKE : RSHIFT_MAKE);
                else if (pick < 75)
                    send_key($urandom_range(1) ? LSHIFT_BREAK : RSHIFT_BREAK);
                else if (pick < 79)
                    send_key(CAPS_MAKE);
                else if (pick < 85)
                begin
                    send_key(SC_PREFIX);
                    send_key(8'($urandom_range(255)));
                end
                else if (pick < 94)
                    send_key(8'($urandom_range(255)));
                else if (pick < 97)
                    send_key(SC_RELEASE | 8'($urandom_range(127)));
                else
                    send_read(7'($urandom_range(1, 64)));
            end
            pick = $urandom_range(99);
            if (pick < 85)
                send_key(KEY_ENTER);
            if (pick < 90)
                send_read(($urandom_range(3) == 0) ? 7'd64 : 7'($urandom_range(1, 64)));
            if ($urandom_range(9) == 0)
                send_read(7'($urandom_range(1, 64)));
            if ($urandom_range(15) == 0)
                drain_results();
        end
    endtask

    task automatic test_back_to_back();
        send_idle_on  = 1'b0;
        recv_stall_on = 1'b0;
        repeat (3)
        begin
            repeat (12) send_key(random_char_code());
            send_key(KEY_ENTER);
            send_read(7'd64);
        end
        drain_results();
        send_idle_on  = 1'b1;
        recv_stall_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        m_tready <= !recv_stall_on || ($urandom_range(99) >= 29);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output: k%0d c%h l%b n%0d",
                             m_tuser, m_tdata[6:0], m_tlast, m_tdata[12:7]);
            end
            else
            begin
                want = results_due.pop_front();
                results_checked++;
                if (m_tuser !== want.kind || m_tdata[6:0] !== want.ch ||
                    m_tlast !== want.last || m_tdata[12:7] !== want.count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want k%0d c%h l%b n%0d, got k%0d c%h l%b n%0d",
                                 want.kind, want.ch, want.last, want.count,
                                 m_tuser, m_tdata[6:0], m_tlast, m_tdata[12:7]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", results_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        line_len   = 0;
        line_done  = 1'b0;
        shift_down = 1'b0;
        caps_lock  = 1'b0;
        e0_pending = 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++)
            line_buf[i] = CH_NONE;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_keymap();
        test_read_cases();
        test_full_line();
        test_random_lines(RANDOM_GOAL);
        test_back_to_back();

        drain_results();
        repeat (20) @(posedge clk);
        $display("Sent %0d requests (%0d line reads) and checked %0d results",
                 items_sent, reads_sent, results_checked);
        $display("Covered shift, caps lock, prefix, backspace, full line and read cases");
        if (mismatches == 0 && results_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
hdl/sle_pkg.sv
hdl/sle_front.sv
hdl/sle_queue.sv
hdl/sle_back.sv
hdl/scancode_line_editor.sv
bench/testbench.sv
